@@ src/ksag_pkg.sv @@
// ----------------------------------------------------------------------------
// ksag_pkg
// Shared constants, types and helper functions of the keyed scatter
// address generator.
// ----------------------------------------------------------------------------
package ksag_pkg;

   // key pairs and dimensions
   localparam int KeyWords = 4;
   localparam int PairCount = 6;
   localparam int DimMax = 16384;

   // n div 6 as (n * recip) >> shift, exact for any 32-bit n
   localparam logic [31:0] Div6Recip = 32'hAAAA_AAAB;
   localparam int Div6Shift = 34;

   // remainder pipe: four quotient bits per stage over a 32-bit sum
   localparam int RemBitsPerStage = 4;
   localparam int RemStages = 32 / RemBitsPerStage;

   // register offsets (word index)
   typedef enum logic [2:0] {
      REG_KEY0   = 3'd0,
      REG_KEY1   = 3'd1,
      REG_KEY2   = 3'd2,
      REG_KEY3   = 3'd3,
      REG_ROWS   = 3'd4,
      REG_COLS   = 3'd5,
      REG_STRIDE = 3'd6
   } csr_index_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [KeyWords-1:0][31:0] key;
      logic [14:0]               row_mod;
      logic [14:0]               col_mod;
      logic [15:0]               stride;
   } cfg_type;

   // first key word of pair k
   function automatic logic [1:0] pair_first(input logic [2:0] k);
      logic [1:0] w;
      case (k)
         3'd0, 3'd1, 3'd2: w = 2'd0;
         3'd3, 3'd4:       w = 2'd1;
         3'd5:             w = 2'd2;
         default:          w = 2'd0;
      endcase
      return w;
   endfunction

   // second key word of pair k
   function automatic logic [1:0] pair_second(input logic [2:0] k);
      logic [1:0] w;
      case (k)
         3'd0:             w = 2'd1;
         3'd1, 3'd3:       w = 2'd2;
         3'd2, 3'd4, 3'd5: w = 2'd3;
         default:          w = 2'd1;
      endcase
      return w;
   endfunction

   // zero held at 1, large values held at the maximum dimension
   function automatic logic [14:0] held_mod(input logic [14:0] v);
      logic [14:0] m;
      if (v == 15'd0) begin
         m = 15'd1;
      end else if (v > 15'(DimMax)) begin
         m = 15'(DimMax);
      end else begin
         m = v;
      end
      return m;
   endfunction

   // restoring remainder over a few quotient bits, msb first
   function automatic logic [13:0] rem_steps(input logic [13:0] r_in,
                                             input logic [RemBitsPerStage-1:0] bits,
                                             input logic [14:0] m);
      logic [14:0] t;
      logic [13:0] r;
      r = r_in;
      for (int i = RemBitsPerStage - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= m) begin
            t = t - m;
         end
         r = t[13:0];
      end
      return r;
   endfunction

endpackage

@@ src/ksag_if.sv @@
// ----------------------------------------------------------------------------
// ksag_if
// Handshake channels of the address generator: index in, address out.
// ----------------------------------------------------------------------------
interface ksag_req_if;
   logic        valid;
   logic        ready;
   logic [30:0] byte_index;

   modport source (output valid, output byte_index, input ready);
   modport sink (input valid, input byte_index, output ready);
endinterface

interface ksag_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] row_pos;
   logic [13:0] col_pos;
   logic [29:0] byte_address;

   modport source (output valid, output row_pos, output col_pos, output byte_address,
                   input ready);
   modport sink (input valid, input row_pos, input col_pos, input byte_address,
                 output ready);
endinterface

@@ src/keyed_scatter_address_gen_core.sv @@
// ----------------------------------------------------------------------------
// keyed_scatter_address_gen_core
// Maps a byte index to a keyed row, column and byte address in an image.
//
//   port group | dir | carries
//   req        | in  | byte_index
//   rsp        | out | row_pos, col_pos, byte_address
//   csr_*      | i/o | key words, image rows, image cols, row stride
//
// One item per cycle while results are taken; 4 front stages, 8 remainder
// stages of 4 quotient bits each, 1 address stage, plus the input register.
// All stages advance together while the output register is empty or taken;
// a held result stops the whole pipe and nothing is dropped.
// Synchronous reset clears all valid bits; csr registers take reset values.
// ----------------------------------------------------------------------------
module keyed_scatter_address_gen_core (
   input  logic        clock,
   input  logic        reset,
   ksag_req_if.sink    req,
   ksag_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ksag_pkg::*;

   cfg_type     cfg;
   logic        en;
   logic        front_valid;
   logic [31:0] row_sum;
   logic [31:0] col_sum;
   logic        rem_valid;
   logic [13:0] row_rem;
   logic [13:0] col_rem;
   logic [30:0] addr_full;

   logic        out_valid_ff;
   logic [13:0] row_ff;
   logic [13:0] col_ff;
   logic [29:0] addr_ff;

   // pipe advance
   assign en = ~out_valid_ff | rsp.ready;
   assign req.ready = en;

   ksag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ksag_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req.valid),
      .byte_index (req.byte_index),
      .key        (cfg.key),
      .out_valid  (front_valid),
      .row_sum    (row_sum),
      .col_sum    (col_sum)
   );

   ksag_rem_pipe u_rem (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .row_sum   (row_sum),
      .col_sum   (col_sum),
      .row_mod   (cfg.row_mod),
      .col_mod   (cfg.col_mod),
      .out_valid (rem_valid),
      .row_rem   (row_rem),
      .col_rem   (col_rem)
   );

   // byte address
   assign addr_full = 31'(row_rem * cfg.stride) + 31'(col_rem);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= rem_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff  <= row_rem;
         col_ff  <= col_rem;
         addr_ff <= addr_full[29:0];
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.row_pos      = row_ff;
   assign rsp.col_pos      = col_ff;
   assign rsp.byte_address = addr_ff;

endmodule

@@ src/ksag_csr.sv @@
// ----------------------------------------------------------------------------
// ksag_csr
// APB-style register file: key words, image dimensions and row stride.
// ----------------------------------------------------------------------------
module ksag_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output ksag_pkg::cfg_type cfg
);
   import ksag_pkg::*;

   logic [KeyWords-1:0][31:0] key_ff;
   logic [14:0]               rows_ff;
   logic [14:0]               cols_ff;
   logic [15:0]               stride_ff;
   logic                      wr_en;
   csr_index_type             idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_index_type'(csr_paddr[4:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         rows_ff   <= 15'd1;
         cols_ff   <= 15'd1;
         stride_ff <= 16'd1;
      end else if (wr_en) begin
         case (idx)
            REG_KEY0:   key_ff[0] <= csr_pwdata;
            REG_KEY1:   key_ff[1] <= csr_pwdata;
            REG_KEY2:   key_ff[2] <= csr_pwdata;
            REG_KEY3:   key_ff[3] <= csr_pwdata;
            REG_ROWS:   rows_ff   <= csr_pwdata[14:0];
            REG_COLS:   cols_ff   <= csr_pwdata[14:0];
            REG_STRIDE: stride_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_KEY0:   csr_prdata = key_ff[0];
         REG_KEY1:   csr_prdata = key_ff[1];
         REG_KEY2:   csr_prdata = key_ff[2];
         REG_KEY3:   csr_prdata = key_ff[3];
         REG_ROWS:   csr_prdata = {17'd0, rows_ff};
         REG_COLS:   csr_prdata = {17'd0, cols_ff};
         REG_STRIDE: csr_prdata = {16'd0, stride_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // datapath view with held moduli
   always_comb begin
      cfg.key     = key_ff;
      cfg.row_mod = held_mod(rows_ff);
      cfg.col_mod = held_mod(cols_ff);
      cfg.stride  = stride_ff;
   end

endmodule

@@ src/ksag_front.sv @@
// ----------------------------------------------------------------------------
// ksag_front
// Front stages: index capture, divide by six, key pair select, products
// and wrapped sums for row and column.
// ----------------------------------------------------------------------------
module ksag_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [30:0]             byte_index,
   input  logic [3:0][31:0]        key,
   output logic                    out_valid,
   output logic [31:0]             row_sum,
   output logic [31:0]             col_sum
);
   import ksag_pkg::*;

   logic [4:0]  vld_ff;
   logic [30:0] n1_ff;
   logic [30:0] n2_ff;
   logic [28:0] q2_ff;
   logic [28:0] q3_ff;
   logic [31:0] a3_ff;
   logic [31:0] b3_ff;
   logic [31:0] a4_ff;
   logic [31:0] b4_ff;
   logic [31:0] qb4_ff;
   logic [31:0] qa4_ff;
   logic [31:0] rsum_ff;
   logic [31:0] csum_ff;

   logic [62:0] div_prod;
   logic [30:0] six_q;
   logic [2:0]  k;
   logic [31:0] q_ext;
   logic [31:0] qb_in;
   logic [31:0] qa_in;

   // valid bits, one per register stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // quotient by reciprocal, pair index from remainder
   assign div_prod = 63'(n1_ff) * 63'(Div6Recip);
   assign six_q = 31'({q2_ff, 2'b00}) + 31'({q2_ff, 1'b0});
   assign k = 3'(n2_ff - six_q);
   assign q_ext = {3'd0, q3_ff};
   assign qb_in = q_ext * b3_ff;
   assign qa_in = q_ext * a3_ff;

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff   <= byte_index;
         n2_ff   <= n1_ff;
         q2_ff   <= div_prod[Div6Shift+28:Div6Shift];
         q3_ff   <= q2_ff;
         a3_ff   <= key[pair_first(k)];
         b3_ff   <= key[pair_second(k)];
         a4_ff   <= a3_ff;
         b4_ff   <= b3_ff;
         qb4_ff  <= qb_in;
         qa4_ff  <= qa_in;
         rsum_ff <= a4_ff + qb4_ff;
         csum_ff <= b4_ff + qa4_ff;
      end
   end

   assign out_valid = vld_ff[4];
   assign row_sum = rsum_ff;
   assign col_sum = csum_ff;

endmodule

@@ src/ksag_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// ksag_rem_pipe
// Pipelined restoring remainder for row and column lanes, a few quotient
// bits per stage, msb first.
// ----------------------------------------------------------------------------
module ksag_rem_pipe (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] row_sum,
   input  logic [31:0] col_sum,
   input  logic [14:0] row_mod,
   input  logic [14:0] col_mod,
   output logic        out_valid,
   output logic [13:0] row_rem,
   output logic [13:0] col_rem
);
   import ksag_pkg::*;

   logic [RemStages-1:0] vld_ff;
   logic [31:0]          rs_ff [RemStages];
   logic [31:0]          cs_ff [RemStages];
   logic [13:0]          rr_ff [RemStages];
   logic [13:0]          cr_ff [RemStages];
   logic [31:0]          rs_in [RemStages];
   logic [31:0]          cs_in [RemStages];
   logic [13:0]          rr_in [RemStages];
   logic [13:0]          cr_in [RemStages];

   // one group of quotient bits per stage
   always_comb begin
      logic [31:0] rs_src;
      logic [31:0] cs_src;
      logic [13:0] rr_src;
      logic [13:0] cr_src;
      for (int s = 0; s < RemStages; s++) begin
         if (s == 0) begin
            rs_src = row_sum;
            cs_src = col_sum;
            rr_src = '0;
            cr_src = '0;
         end else begin
            rs_src = rs_ff[s-1];
            cs_src = cs_ff[s-1];
            rr_src = rr_ff[s-1];
            cr_src = cr_ff[s-1];
         end
         rr_in[s] = rem_steps(rr_src, rs_src[31 -: RemBitsPerStage], row_mod);
         cr_in[s] = rem_steps(cr_src, cs_src[31 -: RemBitsPerStage], col_mod);
         rs_in[s] = rs_src << RemBitsPerStage;
         cs_in[s] = cs_src << RemBitsPerStage;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RemStages-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < RemStages; s++) begin
            rs_ff[s] <= rs_in[s];
            cs_ff[s] <= cs_in[s];
            rr_ff[s] <= rr_in[s];
            cr_ff[s] <= cr_in[s];
         end
      end
   end

   assign out_valid = vld_ff[RemStages-1];
   assign row_rem = rr_ff[RemStages-1];
   assign col_rem = cr_ff[RemStages-1];

endmodule

@@ src/ksag_checker.sv @@
// ----------------------------------------------------------------------------
// ksag_checker
// Port-level checks of the address generator, bound to the top level.
// ----------------------------------------------------------------------------
module ksag_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [13:0] rsp_row_pos
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty output register never stalls the input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a held result stalls the input
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result held");

   // held result stays valid and keeps its row position
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_pos))
      else $error("held result changed");

endmodule

bind keyed_scatter_address_gen_core ksag_checker u_ksag_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_row_pos (rsp.row_pos)
);

@@ bench/keyed_scatter_address_gen_core_test.sv @@
// ----------------------------------------------------------------------------
// keyed_scatter_address_gen_core_test
// Self-checking bench for the keyed scatter address generator: programs key
// words, image size and stride over the csr port, streams byte indexes with
// random gaps and output stalls, and checks every address against a local
// predictor of the row, column and byte address.
// ----------------------------------------------------------------------------
module keyed_scatter_address_gen_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ksag_pkg::*;

   localparam int IdleLimit = 5000;

   typedef struct packed {
      logic [13:0] row_pos;
      logic [13:0] col_pos;
      logic [29:0] byte_address;
   } scatter_pos_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ksag_req_if req ();
   ksag_rsp_if rsp ();

   keyed_scatter_address_gen_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // local copy of the register file
   logic [31:0] key_copy [KeyWords];
   logic [14:0] rows_copy;
   logic [14:0] cols_copy;
   logic [15:0] stride_copy;

   scatter_pos_type expected_pos[$];
   int          error_count;
   int          hold_left;
   bit          sender_gaps;
   bit          receiver_stalls;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // key word index of pair member
   function automatic int pair_word(input int k, input bit second);
      int w;
      case (k)
         0:       w = second ? 1 : 0;
         1:       w = second ? 2 : 0;
         2:       w = second ? 3 : 0;
         3:       w = second ? 2 : 1;
         4:       w = second ? 3 : 1;
         default: w = second ? 3 : 2;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] clamp_dim(input logic [14:0] v);
      logic [31:0] m;
      if (v == 15'd0) begin
         m = 32'd1;
      end else if (v > 15'(DimMax)) begin
         m = 32'(DimMax);
      end else begin
         m = {17'd0, v};
      end
      return m;
   endfunction

   // expected row, column and address for one byte index
   function automatic scatter_pos_type predict_position(input logic [30:0] n);
      scatter_pos_type p;
      logic [31:0] n32, q, a, b, rsum, csum, row, col;
      logic [63:0] addr;
      int          k;
      n32 = {1'b0, n};
      k = int'(n32 % 32'd6);
      q = n32 / 32'd6;
      a = key_copy[pair_word(k, 1'b0)];
      b = key_copy[pair_word(k, 1'b1)];
      rsum = a + q * b;
      csum = b + q * a;
      row = rsum % clamp_dim(rows_copy);
      col = csum % clamp_dim(cols_copy);
      addr = 64'(row) * 64'(stride_copy) + 64'(col);
      p.row_pos = row[13:0];
      p.col_pos = col[13:0];
      p.byte_address = addr[29:0];
      return p;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result side: random stalls, long hold-off, field checks
   initial begin
      int stall;
      scatter_pos_type want;
      stall = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_pos.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp.byte_address), 32'd0);
            end else begin
               want = expected_pos.pop_front();
               if (rsp.row_pos !== want.row_pos)
                  report_mismatch("row_pos", 32'(rsp.row_pos), 32'(want.row_pos));
               if (rsp.col_pos !== want.col_pos)
                  report_mismatch("col_pos", 32'(rsp.col_pos), 32'(want.col_pos));
               if (rsp.byte_address !== want.byte_address)
                  report_mismatch("byte_address", 32'(rsp.byte_address),
                                  32'(want.byte_address));
            end
            stall = receiver_stalls ? $urandom_range(0, 3) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no traffic
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel) begin
            idle = 0;
         end else begin
            idle++;
         end
         if (idle >= IdleLimit) begin
            $display("keyed_scatter_address_gen_core verification failed");
            $finish;
         end
      end
   end

   // send one byte index, valid stays high if the next gap is zero
   task automatic send_index(input logic [30:0] n);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.byte_index <= n;
      do @(posedge clock); while (!req.ready);
      expected_pos = {expected_pos, predict_position(n)};
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      while (expected_pos.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // register write: setup then access cycle
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_KEY0:   key_copy[0] = value;
         REG_KEY1:   key_copy[1] = value;
         REG_KEY2:   key_copy[2] = value;
         REG_KEY3:   key_copy[3] = value;
         REG_ROWS:   rows_copy = value[14:0];
         REG_COLS:   cols_copy = value[14:0];
         REG_STRIDE: stride_copy = value[15:0];
         default:    ;
      endcase
   endtask

   task automatic load_setup(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3,
                             input logic [31:0] rows, input logic [31:0] cols,
                             input logic [31:0] stride);
      write_reg(REG_KEY0, k0);
      write_reg(REG_KEY1, k1);
      write_reg(REG_KEY2, k2);
      write_reg(REG_KEY3, k3);
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLS, cols);
      write_reg(REG_STRIDE, stride);
   endtask

   function automatic logic [30:0] random_index();
      logic [30:0] n;
      case ($urandom_range(0, 3))
         0:       n = 31'($urandom_range(0, 200));
         1:       n = 31'h7FFF_FFFF - 31'($urandom_range(0, 50));
         default: n = 31'($urandom);
      endcase
      return n;
   endfunction

   // reset register values
   task automatic test_reset_values;
      for (int i = 0; i < 6; i++) send_index(31'(i));
      send_index(31'h7FFF_FFFF);
      drain();
   endtask

   // every pair, extreme indexes, extreme dimensions and stride
   task automatic test_directed;
      load_setup(32'h1234_5678, 32'h9ABC_DEF1, 32'h0F0F_0F0F, 32'hFFFF_FFFF,
                 32'd100, 32'd77, 32'd640);
      for (int i = 0; i < 12; i++) send_index(31'(i));
      send_index(31'h7FFF_FFFF);
      send_index(31'h7FFF_FFFA);
      drain();
      // zero rows and cols held at one, zero stride
      load_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'd0, 32'd0, 32'd0);
      send_index(31'd5);
      send_index(31'h4000_0001);
      drain();
      // largest dimension, above-max dimension, full stride, masked upper bits
      write_reg(REG_ROWS, 32'd16384);
      write_reg(REG_COLS, 32'hFFFF_7FFF);
      write_reg(REG_STRIDE, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send_index(31'h7FFF_FFFF - 31'(i));
      drain();
      // write to an unused address does nothing
      write_reg(csr_index_type'(3'd7), 32'hDEAD_BEEF);
      write_reg(REG_ROWS, 32'd16385);
      write_reg(REG_COLS, 32'd16383);
      for (int i = 0; i < 4; i++) send_index(random_index());
      drain();
   endtask

   // random settings, random indexes
   task automatic test_random_stream;
      logic [31:0] rows, cols;
      for (int phase = 0; phase < 9; phase++) begin
         if (phase < 6) begin
            rows = $urandom_range(1, 300);
            cols = $urandom_range(1, 300);
         end else begin
            rows = $urandom;
            cols = $urandom;
         end
         load_setup($urandom, $urandom, $urandom, $urandom, rows, cols, $urandom);
         sender_gaps = (phase != 2);
         receiver_stalls = (phase != 3);
         for (int i = 0; i < 40; i++) send_index(random_index());
         drain();
      end
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // output held off while indexes keep coming, then a full drain pause
   task automatic test_backpressure;
      load_setup($urandom, $urandom, $urandom, $urandom, 32'd1000, 32'd999, 32'd1024);
      hold_left = 200;
      sender_gaps = 1'b0;
      for (int i = 0; i < 50; i++) send_index(random_index());
      sender_gaps = 1'b1;
      drain();
      for (int i = 0; i < 20; i++) send_index(random_index());
      drain();
   endtask

   initial begin
      error_count = 0;
      hold_left = 0;
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      key_copy = '{default: 32'd0};
      rows_copy = 15'd1;
      cols_copy = 15'd1;
      stride_copy = 16'd1;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.byte_index <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed();
      test_random_stream();
      test_backpressure();

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("keyed_scatter_address_gen_core verification clean");
      end else begin
         $display("keyed_scatter_address_gen_core verification failed");
      end
      $finish;
   end

endmodule
